@@ src/efl_pkg.sv @@
`default_nettype none

package efl_pkg;

   typedef logic [31:0] efl_word_type;

   // Request kinds on the input channel.
   localparam logic REQ_ALLOC = 1'b0;
   localparam logic REQ_FREE  = 1'b1;

   // Response status codes.
   localparam logic [1:0] ST_DONE      = 2'd0;
   localparam logic [1:0] ST_NO_SPACE  = 2'd1;
   localparam logic [1:0] ST_ZERO_SIZE = 2'd2;

   // Boundary tag layout: size in the upper bits, allocated flag in bit 0.
   localparam efl_word_type SIZE_MASK = 32'hFFFF_FFF8;
   localparam efl_word_type ALLOC_BIT = 32'h0000_0001;
   localparam efl_word_type MIN_SPLIT = 32'd16;

   // One access slot to the heap memory; byte addresses, word aligned.
   typedef struct packed {
      logic         rd_en;
      efl_word_type rd_addr;
      logic         wr_en;
      efl_word_type wr_addr;
      efl_word_type wr_data;
   } efl_mem_req_type;

endpackage

`default_nettype wire

@@ src/efl_ram.sv @@
`default_nettype none

module efl_ram import efl_pkg::*; #(
   parameter int ADDR_BITS = 14
) (
   input  wire logic            clock,
   input  efl_mem_req_type      mem_req,
   output efl_word_type         mem_rdata
);

   efl_word_type mem [2**ADDR_BITS];
   efl_word_type rdata_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem[mem_req.wr_addr[ADDR_BITS+1:2]] <= mem_req.wr_data;
      end
      if (mem_req.rd_en) begin
         rdata_ff <= mem[mem_req.rd_addr[ADDR_BITS+1:2]];
      end
   end

   assign mem_rdata = rdata_ff;

endmodule

`default_nettype wire

@@ src/efl_seq.sv @@
`default_nettype none

module efl_seq import efl_pkg::*; #(
   parameter int HEAP_BYTES  = 65536,
   parameter int CHUNK_BYTES = 4096
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_type,
   input  wire logic [15:0] req_alloc_size,
   input  wire logic [15:0] req_block_offset,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [15:0]      rsp_payload_offset,
   output logic [1:0]       rsp_status,
   input  wire logic        csr_wr_en,
   input  wire logic [16:0] csr_wr_data,
   output efl_mem_req_type  mem_req,
   input  efl_word_type     mem_rdata
);

   localparam int CHUNK_Q    = CHUNK_BYTES / 4;
   localparam int CHUNK8     = (CHUNK_Q + CHUNK_Q % 2) * 4;
   localparam bit INIT_FITS  = (16 + CHUNK8) <= HEAP_BYTES;
   localparam int WALK_MAX   = HEAP_BYTES / 16;
   localparam int CNT_BITS   = $clog2(WALK_MAX + 2);
   localparam efl_word_type CHUNK_W   = 32'(CHUNK8);
   localparam efl_word_type CHUNK_RAW = 32'(CHUNK_BYTES);
   localparam efl_word_type HEAP_W    = 32'(HEAP_BYTES);
   localparam efl_word_type HEAD_INIT = INIT_FITS ? 32'd16 : 32'd0;
   localparam efl_word_type BRK_INIT  = INIT_FITS ? 32'(16 + CHUNK8) : 32'd16;
   localparam logic [2:0]   INIT_LAST = INIT_FITS ? 3'd6 : 3'd2;
   localparam logic [CNT_BITS-1:0] CNT_MAX = CNT_BITS'(WALK_MAX);

   typedef enum logic [5:0] {
      S_INIT, S_IDLE, S_DONE,
      S_F_RD, S_F_W0, S_F_W1, S_F_W2, S_F_W3,
      S_M_RA, S_M_RB, S_M_RC, S_M_RD, S_M_RE, S_M_DEC,
      S_M_A1, S_M_A2, S_M_A3,
      S_M_B1, S_M_B2, S_M_B3, S_M_B4,
      S_M_C1, S_M_C2, S_M_C3, S_M_C4, S_M_C5,
      S_M_PUSH, S_M_P2,
      S_U_RD, S_U_CK, S_U_P, S_U_N, S_U_W1, S_U_W2, S_U_W3,
      S_FF_CHK, S_FF_CMP, S_FF_NX,
      S_G_START, S_G_W0, S_G_W1, S_G_W2, S_G_W3, S_G_W4, S_G_RET,
      S_C_RD, S_C_SZ, S_C_DEC,
      S_C_W0, S_C_W1, S_C_W2, S_C_W3, S_C_W4, S_C_W5,
      S_C_X0, S_C_X1, S_C_END
   } state_type;

   state_type           state_ff, mg_ret_ff, ul_ret_ff;
   logic [2:0]          init_cnt_ff;
   logic [CNT_BITS-1:0] cnt_ff;
   logic [16:0]         limit_ff;
   logic [15:0]         off_ff;
   efl_word_type        asize_ff;
   efl_word_type        head_ff, brk_ff;
   efl_word_type        mbp_ff, pb_ff, nb_ff, msz_ff, s_ff;
   efl_word_type        x_ff, p_ff, n_ff;
   efl_word_type        bp_ff, cbp_ff, csz_ff, gsz_ff;
   logic                pa_ff;
   logic [15:0]         pay_ff;
   logic [1:0]          st_ff;
   logic                rsp_valid_ff;
   logic [15:0]         rsp_pay_ff;
   logic [1:0]          rsp_st_ff;

   efl_word_type rd_size, off_w, d_w, gsz_w, lim_w, rest_w, asize_w;
   logic [32:0]  grow_end;

   assign rd_size  = mem_rdata & SIZE_MASK;
   assign off_w    = {16'd0, off_ff};
   assign d_w      = csz_ff - asize_ff;
   assign rest_w   = cbp_ff + asize_ff;
   assign gsz_w    = (asize_ff > CHUNK_RAW) ? asize_ff : CHUNK_W;
   assign lim_w    = ({15'd0, limit_ff} < HEAP_W) ? {15'd0, limit_ff} : HEAP_W;
   assign grow_end = {1'b0, brk_ff} + {1'b0, gsz_w};
   assign asize_w  = (req_alloc_size <= 16'd8) ? 32'd16 :
                     ({15'd0, {1'b0, req_alloc_size} + 17'd15} & SIZE_MASK);

   assign req_ready          = (state_ff == S_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_payload_offset = rsp_pay_ff;
   assign rsp_status         = rsp_st_ff;

   // memory access for the current step
   always_comb begin
      mem_req = '0;
      case (state_ff)
         S_INIT: begin
            mem_req.wr_en = 1'b1;
            case (init_cnt_ff)
               3'd0: begin mem_req.wr_addr = 32'd4;  mem_req.wr_data = 32'd9; end
               3'd1: begin mem_req.wr_addr = 32'd8;  mem_req.wr_data = 32'd9; end
               3'd2: begin
                  mem_req.wr_addr = 32'd12;
                  mem_req.wr_data = INIT_FITS ? CHUNK_W : ALLOC_BIT;
               end
               3'd3: begin mem_req.wr_addr = CHUNK_W + 32'd8;  mem_req.wr_data = CHUNK_W; end
               3'd4: begin mem_req.wr_addr = 32'd20; mem_req.wr_data = '0; end
               3'd5: begin mem_req.wr_addr = 32'd16; mem_req.wr_data = '0; end
               3'd6: begin mem_req.wr_addr = CHUNK_W + 32'd12; mem_req.wr_data = ALLOC_BIT; end
               default: mem_req.wr_en = 1'b0;
            endcase
         end
         S_F_RD: begin mem_req.rd_en = 1'b1; mem_req.rd_addr = off_w - 32'd4; end
         S_F_W0: begin
            mem_req.wr_en = 1'b1; mem_req.wr_addr = off_w - 32'd4; mem_req.wr_data = rd_size;
         end
         S_F_W1: begin
            mem_req.wr_en = 1'b1; mem_req.wr_addr = off_w + msz_ff - 32'd8;
            mem_req.wr_data = msz_ff;
         end
         S_F_W2: begin mem_req.wr_en = 1'b1; mem_req.wr_addr = off_w + 32'd4; end
         S_F_W3: begin mem_req.wr_en = 1'b1; mem_req.wr_addr = off_w; end
         S_M_RA: begin mem_req.rd_en = 1'b1; mem_req.rd_addr = mbp_ff - 32'd8; end
         S_M_RB: begin mem_req.rd_en = 1'b1; mem_req.rd_addr = mbp_ff - 32'd4; end
         S_M_RC: begin mem_req.rd_en = 1'b1; mem_req.rd_addr = pb_ff - 32'd4; end
         S_M_RD: begin mem_req.rd_en = 1'b1; mem_req.rd_addr = pb_ff + rd_size - 32'd8; end
         S_M_RE: begin mem_req.rd_en = 1'b1; mem_req.rd_addr = nb_ff - 32'd4; end
         S_M_A1: begin mem_req.rd_en = 1'b1; mem_req.rd_addr = nb_ff - 32'd4; end
         S_M_A2: begin
            mem_req.wr_en = 1'b1; mem_req.wr_addr = mbp_ff - 32'd4;
            mem_req.wr_data = msz_ff + rd_size;
         end
         S_M_A3: begin
            mem_req.wr_en = 1'b1; mem_req.wr_addr = mbp_ff + s_ff - 32'd8; mem_req.wr_data = s_ff;
         end
         S_M_B1: begin mem_req.rd_en = 1'b1; mem_req.rd_addr = pb_ff - 32'd4; end
         S_M_B2: begin mem_req.rd_en = 1'b1; mem_req.rd_addr = mbp_ff - 32'd4; end
         S_M_B3: begin
            mem_req.wr_en = 1'b1; mem_req.wr_addr = mbp_ff + rd_size - 32'd8;
            mem_req.wr_data = s_ff;
         end
         S_M_B4: begin
            mem_req.wr_en = 1'b1; mem_req.wr_addr = pb_ff - 32'd4; mem_req.wr_data = s_ff;
         end
         S_M_C2: begin mem_req.rd_en = 1'b1; mem_req.rd_addr = pb_ff - 32'd4; end
         S_M_C3: begin mem_req.rd_en = 1'b1; mem_req.rd_addr = nb_ff - 32'd4; end
         S_M_C4: begin
            mem_req.wr_en = 1'b1; mem_req.wr_addr = nb_ff + rd_size - 32'd8;
            mem_req.wr_data = s_ff + rd_size;
         end
         S_M_C5: begin
            mem_req.wr_en = 1'b1; mem_req.wr_addr = pb_ff - 32'd4; mem_req.wr_data = s_ff;
         end
         S_M_PUSH: begin
            mem_req.wr_en   = (mbp_ff != '0) && (head_ff != '0);
            mem_req.wr_addr = mbp_ff + 32'd4;
            mem_req.wr_data = head_ff;
         end
         S_M_P2: begin
            mem_req.wr_en = 1'b1; mem_req.wr_addr = head_ff; mem_req.wr_data = mbp_ff;
         end
         S_U_RD: begin mem_req.rd_en = (x_ff != '0); mem_req.rd_addr = x_ff - 32'd4; end
         S_U_CK: begin mem_req.rd_en = !mem_rdata[0]; mem_req.rd_addr = x_ff; end
         S_U_P:  begin mem_req.rd_en = 1'b1; mem_req.rd_addr = x_ff + 32'd4; end
         S_U_N:  begin mem_req.wr_en = 1'b1; mem_req.wr_addr = x_ff; end
         S_U_W1: begin mem_req.wr_en = 1'b1; mem_req.wr_addr = x_ff + 32'd4; end
         S_U_W2: begin
            if (p_ff == '0 && n_ff != '0) begin
               mem_req.wr_en = 1'b1; mem_req.wr_addr = n_ff;
            end else if (p_ff != '0) begin
               mem_req.wr_en = 1'b1; mem_req.wr_addr = p_ff + 32'd4; mem_req.wr_data = n_ff;
            end
         end
         S_U_W3: begin mem_req.wr_en = 1'b1; mem_req.wr_addr = n_ff; mem_req.wr_data = p_ff; end
         S_FF_CHK: begin
            mem_req.rd_en   = (bp_ff != '0) && (cnt_ff <= CNT_MAX);
            mem_req.rd_addr = bp_ff - 32'd4;
         end
         S_FF_CMP: begin
            mem_req.rd_en = (rd_size < asize_ff); mem_req.rd_addr = bp_ff + 32'd4;
         end
         S_G_W0: begin
            mem_req.wr_en = 1'b1; mem_req.wr_addr = mbp_ff - 32'd4; mem_req.wr_data = gsz_ff;
         end
         S_G_W1: begin
            mem_req.wr_en = 1'b1; mem_req.wr_addr = mbp_ff + gsz_ff - 32'd8;
            mem_req.wr_data = gsz_ff;
         end
         S_G_W2: begin mem_req.wr_en = 1'b1; mem_req.wr_addr = mbp_ff + 32'd4; end
         S_G_W3: begin mem_req.wr_en = 1'b1; mem_req.wr_addr = mbp_ff; end
         S_G_W4: begin
            mem_req.wr_en = 1'b1; mem_req.wr_addr = mbp_ff + gsz_ff - 32'd4;
            mem_req.wr_data = ALLOC_BIT;
         end
         S_C_RD: begin mem_req.rd_en = 1'b1; mem_req.rd_addr = cbp_ff - 32'd4; end
         S_C_W0: begin
            mem_req.wr_en = 1'b1; mem_req.wr_addr = cbp_ff - 32'd4;
            mem_req.wr_data = asize_ff | ALLOC_BIT;
         end
         S_C_W1: begin
            mem_req.wr_en = 1'b1; mem_req.wr_addr = rest_w - 32'd8;
            mem_req.wr_data = asize_ff | ALLOC_BIT;
         end
         S_C_W2: begin
            mem_req.wr_en = 1'b1; mem_req.wr_addr = rest_w - 32'd4; mem_req.wr_data = d_w;
         end
         S_C_W3: begin
            mem_req.wr_en = 1'b1; mem_req.wr_addr = rest_w + d_w - 32'd8; mem_req.wr_data = d_w;
         end
         S_C_W4: begin mem_req.wr_en = 1'b1; mem_req.wr_addr = rest_w; end
         S_C_W5: begin mem_req.wr_en = 1'b1; mem_req.wr_addr = rest_w + 32'd4; end
         S_C_X0: begin
            mem_req.wr_en = 1'b1; mem_req.wr_addr = cbp_ff - 32'd4;
            mem_req.wr_data = csz_ff | ALLOC_BIT;
         end
         S_C_X1: begin
            mem_req.wr_en = 1'b1; mem_req.wr_addr = cbp_ff + csz_ff - 32'd8;
            mem_req.wr_data = csz_ff | ALLOC_BIT;
         end
         default: mem_req = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         mg_ret_ff    <= S_DONE;
         ul_ret_ff    <= S_DONE;
         init_cnt_ff  <= '0;
         cnt_ff       <= '0;
         limit_ff     <= 17'h10000;
         head_ff      <= HEAD_INIT;
         brk_ff       <= BRK_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            limit_ff <= csr_wr_data;
         end
         // drop the response beat once taken; S_DONE reloads it itself
         if (rsp_valid_ff && rsp_ready && state_ff != S_DONE) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_INIT: begin
               init_cnt_ff <= init_cnt_ff + 3'd1;
               if (init_cnt_ff == INIT_LAST) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (req_valid) begin
                  off_ff   <= req_block_offset;
                  asize_ff <= asize_w;
                  pay_ff   <= '0;
                  st_ff    <= ST_DONE;
                  bp_ff    <= head_ff;
                  cnt_ff   <= '0;
                  if (req_type == REQ_FREE) begin
                     state_ff <= (req_block_offset == '0) ? S_DONE : S_F_RD;
                  end else if (req_alloc_size == '0) begin
                     st_ff    <= ST_ZERO_SIZE;
                     state_ff <= S_DONE;
                  end else begin
                     state_ff <= S_FF_CHK;
                  end
               end
            end
            S_DONE: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_pay_ff   <= pay_ff;
                  rsp_st_ff    <= st_ff;
                  state_ff     <= S_IDLE;
               end
            end
            // free: clear the tags and links, then coalesce
            S_F_RD: state_ff <= S_F_W0;
            S_F_W0: begin msz_ff <= rd_size; state_ff <= S_F_W1; end
            S_F_W1: state_ff <= S_F_W2;
            S_F_W2: state_ff <= S_F_W3;
            S_F_W3: begin
               mbp_ff    <= off_w;
               mg_ret_ff <= S_DONE;
               state_ff  <= S_M_RA;
            end
            // coalesce: probe both neighbors
            S_M_RA: state_ff <= S_M_RB;
            S_M_RB: begin pb_ff <= mbp_ff - rd_size; state_ff <= S_M_RC; end
            S_M_RC: begin
               msz_ff   <= rd_size;
               nb_ff    <= mbp_ff + rd_size;
               state_ff <= S_M_RD;
            end
            S_M_RD: state_ff <= S_M_RE;
            S_M_RE: begin pa_ff <= mem_rdata[0]; state_ff <= S_M_DEC; end
            S_M_DEC: begin
               if (pa_ff && mem_rdata[0]) begin
                  state_ff <= S_M_PUSH;
               end else if (pa_ff) begin
                  x_ff <= nb_ff; ul_ret_ff <= S_M_A1; state_ff <= S_U_RD;
               end else if (mem_rdata[0]) begin
                  x_ff <= pb_ff; ul_ret_ff <= S_M_B1; state_ff <= S_U_RD;
               end else begin
                  x_ff <= nb_ff; ul_ret_ff <= S_M_C1; state_ff <= S_U_RD;
               end
            end
            S_M_A1: state_ff <= S_M_A2;
            S_M_A2: begin s_ff <= msz_ff + rd_size; state_ff <= S_M_A3; end
            S_M_A3: state_ff <= S_M_PUSH;
            S_M_B1: state_ff <= S_M_B2;
            S_M_B2: begin s_ff <= msz_ff + rd_size; state_ff <= S_M_B3; end
            S_M_B3: state_ff <= S_M_B4;
            S_M_B4: begin mbp_ff <= pb_ff; state_ff <= S_M_PUSH; end
            S_M_C1: begin x_ff <= pb_ff; ul_ret_ff <= S_M_C2; state_ff <= S_U_RD; end
            S_M_C2: state_ff <= S_M_C3;
            S_M_C3: begin s_ff <= msz_ff + rd_size; state_ff <= S_M_C4; end
            S_M_C4: begin s_ff <= s_ff + rd_size; state_ff <= S_M_C5; end
            S_M_C5: begin mbp_ff <= pb_ff; state_ff <= S_M_PUSH; end
            S_M_PUSH: begin
               if (mbp_ff == '0) begin
                  state_ff <= mg_ret_ff;
               end else if (head_ff != '0) begin
                  state_ff <= S_M_P2;
               end else begin
                  head_ff  <= mbp_ff;
                  state_ff <= mg_ret_ff;
               end
            end
            S_M_P2: begin head_ff <= mbp_ff; state_ff <= mg_ret_ff; end
            // unlink x from the free list
            S_U_RD: state_ff <= (x_ff == '0) ? ul_ret_ff : S_U_CK;
            S_U_CK: state_ff <= mem_rdata[0] ? ul_ret_ff : S_U_P;
            S_U_P:  begin p_ff <= mem_rdata; state_ff <= S_U_N; end
            S_U_N:  begin n_ff <= mem_rdata; state_ff <= S_U_W1; end
            S_U_W1: state_ff <= S_U_W2;
            S_U_W2: begin
               if (p_ff == '0 && n_ff == '0) begin
                  head_ff <= '0; state_ff <= ul_ret_ff;
               end else if (p_ff == '0) begin
                  head_ff <= n_ff; state_ff <= ul_ret_ff;
               end else if (n_ff == '0) begin
                  state_ff <= ul_ret_ff;
               end else begin
                  state_ff <= S_U_W3;
               end
            end
            S_U_W3: state_ff <= ul_ret_ff;
            // first-fit walk, one node per two reads
            S_FF_CHK: begin
               state_ff <= ((bp_ff != '0) && (cnt_ff <= CNT_MAX)) ? S_FF_CMP : S_G_START;
            end
            S_FF_CMP: begin
               if (rd_size >= asize_ff) begin
                  cbp_ff <= bp_ff; state_ff <= S_C_RD;
               end else begin
                  state_ff <= S_FF_NX;
               end
            end
            S_FF_NX: begin
               bp_ff    <= mem_rdata;
               cnt_ff   <= cnt_ff + 1'b1;
               state_ff <= S_FF_CHK;
            end
            // extend the break
            S_G_START: begin
               if (grow_end > {1'b0, lim_w}) begin
                  st_ff <= ST_NO_SPACE; state_ff <= S_DONE;
               end else begin
                  mbp_ff   <= brk_ff;
                  gsz_ff   <= gsz_w;
                  brk_ff   <= grow_end[31:0];
                  state_ff <= S_G_W0;
               end
            end
            S_G_W0: state_ff <= S_G_W1;
            S_G_W1: state_ff <= S_G_W2;
            S_G_W2: state_ff <= S_G_W3;
            S_G_W3: state_ff <= S_G_W4;
            S_G_W4: begin mg_ret_ff <= S_G_RET; state_ff <= S_M_RA; end
            S_G_RET: begin
               cbp_ff <= mbp_ff;
               if (mbp_ff == '0) begin
                  st_ff <= ST_NO_SPACE; state_ff <= S_DONE;
               end else begin
                  state_ff <= S_C_RD;
               end
            end
            // carve the chosen block, split off a remainder if at least MIN_SPLIT bytes
            S_C_RD: state_ff <= S_C_SZ;
            S_C_SZ: begin
               csz_ff    <= rd_size;
               x_ff      <= cbp_ff;
               ul_ret_ff <= S_C_DEC;
               state_ff  <= S_U_RD;
            end
            S_C_DEC: state_ff <= (d_w >= MIN_SPLIT) ? S_C_W0 : S_C_X0;
            S_C_W0: state_ff <= S_C_W1;
            S_C_W1: state_ff <= S_C_W2;
            S_C_W2: state_ff <= S_C_W3;
            S_C_W3: state_ff <= S_C_W4;
            S_C_W4: state_ff <= S_C_W5;
            S_C_W5: begin
               mbp_ff    <= rest_w;
               mg_ret_ff <= S_C_END;
               state_ff  <= S_M_RA;
            end
            S_C_X0: state_ff <= S_C_X1;
            S_C_X1: state_ff <= S_C_END;
            S_C_END: begin pay_ff <= cbp_ff[15:0]; state_ff <= S_DONE; end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

`default_nettype wire

@@ src/explicit_free_list_allocator.sv @@
`default_nettype none

// Explicit free list heap allocator over a word memory of HEAP_BYTES bytes
// (HEAP_BYTES a power of two). Each block has boundary-tag header and footer
// words; free blocks sit on a doubly linked LIFO list. An allocate beat
// returns a payload byte offset (status 0), status 1 when the heap cannot
// grow within the limit register, or status 2 for a zero size; a free beat
// always answers status 0 with offset 0. One request is worked at a time
// by a sequencer that makes at most one memory access per cycle on a
// synchronous heap RAM with one write port and one registered read port. A
// free clears the tags and links of the block, then coalesces it with any
// free neighbors; an allocate walks the free list first-fit, extends the
// break when no block fits, then carves the block and splits off and
// coalesces a remainder of MIN_SPLIT bytes or more. After reset a setup
// writes the prologue, the first free chunk (when it fits in the heap) and
// the epilogue; req_ready stays low until it is done.
// A new request is taken while the previous response beat still waits.
// The limit register may be written only while the block is idle.
module explicit_free_list_allocator import efl_pkg::*; #(
   parameter int HEAP_BYTES  = 65536,
   parameter int CHUNK_BYTES = 4096
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_type,
   input  wire logic [15:0] req_alloc_size,
   input  wire logic [15:0] req_block_offset,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [15:0]      rsp_payload_offset,
   output logic [1:0]       rsp_status,
   input  wire logic        csr_wr_en,
   input  wire logic [16:0] csr_wr_data
);

   localparam int ADDR_BITS = $clog2(HEAP_BYTES / 4);

   efl_mem_req_type mem_req;
   efl_word_type    mem_rdata;

   // sequencer: walk, split, coalesce and list updates
   efl_seq #(
      .HEAP_BYTES  (HEAP_BYTES),
      .CHUNK_BYTES (CHUNK_BYTES)
   ) u_seq (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_type           (req_type),
      .req_alloc_size     (req_alloc_size),
      .req_block_offset   (req_block_offset),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_payload_offset (rsp_payload_offset),
      .rsp_status         (rsp_status),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .mem_req            (mem_req),
      .mem_rdata          (mem_rdata)
   );

   // heap words
   efl_ram #(
      .ADDR_BITS (ADDR_BITS)
   ) u_ram (
      .clock     (clock),
      .mem_req   (mem_req),
      .mem_rdata (mem_rdata)
   );

   // a step never reads and writes the heap together: no forwarding needed
   assert property (@(posedge clock) disable iff (reset)
      !(mem_req.rd_en && mem_req.wr_en))
      else $error("heap read and write in the same cycle");

   // a failed or zero-size allocate carries no offset
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_DONE |-> rsp_payload_offset == '0)
      else $error("offset on a failed response");

   // status code 3 is never produced
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status != 2'd3)
      else $error("undefined status code");

   // requests are held off when reset falls, as the heap setup begins
   assert property (@(posedge clock) $fell(reset) |-> !req_ready)
      else $error("request taken during heap setup");

endmodule

`default_nettype wire

@@ tb/sv/explicit_free_list_allocator_checker.sv @@
`default_nettype none

module explicit_free_list_allocator_checker import efl_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_ready,
   input  wire logic        req_type,
   input  wire logic [15:0] req_alloc_size,
   input  wire logic [15:0] req_block_offset,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_ready,
   input  wire logic [15:0] rsp_payload_offset,
   input  wire logic [1:0]  rsp_status,
   input  wire logic        csr_wr_en,
   input  wire logic [16:0] csr_wr_data,
   output int               fail_count,
   output int               pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned HEAP_SIZE  = 65536;
   localparam int unsigned CHUNK_SIZE = 4096;
   localparam int unsigned WALK_MAX   = HEAP_SIZE / 16;

   typedef struct {
      logic [15:0] offset;
      logic [1:0]  status;
   } alloc_result_type;

   efl_word_type     heap_mem [0:16383];
   efl_word_type     brk_off;
   efl_word_type     list_head;
   efl_word_type     limit_reg;
   alloc_result_type answer_q[$];

   initial begin
      fail_count    = 0;
      pending_count = 0;
   end

   function automatic efl_word_type peek(input efl_word_type a);
      return heap_mem[a[15:2]];
   endfunction

   function automatic void poke(input efl_word_type a, input efl_word_type v);
      heap_mem[a[15:2]] = v;
   endfunction

   function automatic efl_word_type blk_size(input efl_word_type bp);
      return peek(bp - 4) & SIZE_MASK;
   endfunction

   function automatic bit is_used(input efl_word_type a);
      return (peek(a) & ALLOC_BIT) != 0;
   endfunction

   function automatic efl_word_type footer_of(input efl_word_type bp);
      return bp + blk_size(bp) - 8;
   endfunction

   function automatic efl_word_type next_blk(input efl_word_type bp);
      return bp + blk_size(bp);
   endfunction

   function automatic efl_word_type prev_blk(input efl_word_type bp);
      return bp - (peek(bp - 8) & SIZE_MASK);
   endfunction

   function automatic void unlink_blk(input efl_word_type bp);
      efl_word_type p, n;
      if (bp == 0 || is_used(bp - 4)) return;
      p = peek(bp);
      n = peek(bp + 4);
      poke(bp, 0);
      poke(bp + 4, 0);
      if (p == 0 && n == 0) list_head = 0;
      else if (p == 0) begin
         list_head = n;
         poke(n, 0);
      end else if (n == 0) poke(p + 4, 0);
      else begin
         poke(p + 4, n);
         poke(n, p);
      end
   endfunction

   function automatic void push_blk(input efl_word_type bp);
      if (bp == 0) return;
      if (list_head != 0) begin
         poke(bp + 4, list_head);
         poke(list_head, bp);
      end
      list_head = bp;
   endfunction

   function automatic efl_word_type coalesce(input efl_word_type bp_in);
      efl_word_type bp, pb, nb, sz;
      bit pu, nu;
      bp = bp_in;
      pb = prev_blk(bp);
      nb = next_blk(bp);
      pu = is_used(footer_of(pb));
      nu = is_used(nb - 4);
      sz = blk_size(bp);
      if (pu && nu) begin
         // both neighbors busy: nothing to join
      end else if (pu) begin
         unlink_blk(nb);
         sz += blk_size(nb);
         poke(bp - 4, sz);
         poke(footer_of(bp), sz);
      end else if (nu) begin
         unlink_blk(pb);
         sz += blk_size(pb);
         poke(footer_of(bp), sz);
         poke(pb - 4, sz);
         bp = pb;
      end else begin
         unlink_blk(nb);
         unlink_blk(pb);
         sz += blk_size(pb) + blk_size(nb);
         poke(footer_of(nb), sz);
         poke(pb - 4, sz);
         bp = pb;
      end
      push_blk(bp);
      return bp;
   endfunction

   function automatic efl_word_type grow_heap(input efl_word_type bytes);
      efl_word_type words, sz, bp, lim;
      logic [63:0] top_end;
      words = bytes / 4;
      if (words[0]) words++;
      sz  = words * 4;
      lim = (limit_reg < HEAP_SIZE) ? limit_reg : HEAP_SIZE;
      bp  = brk_off;
      top_end = 64'(bp) + 64'(sz);
      if (top_end > 64'(lim)) return 0;
      brk_off = bp + sz;
      poke(bp - 4, sz);
      poke(footer_of(bp), sz);
      poke(bp + 4, 0);
      poke(bp, 0);
      poke(next_blk(bp) - 4, 1);
      return coalesce(bp);
   endfunction

   function automatic efl_word_type search_list(input efl_word_type asize);
      efl_word_type bp;
      int unsigned n;
      bp = list_head;
      for (n = 0; bp != 0 && n <= WALK_MAX; n++) begin
         if (blk_size(bp) >= asize) return bp;
         bp = peek(bp + 4);
      end
      return 0;
   endfunction

   function automatic void split_blk(input efl_word_type bp, input efl_word_type asize);
      efl_word_type sz, rest, dummy;
      sz = blk_size(bp);
      unlink_blk(bp);
      if (sz - asize >= MIN_SPLIT) begin
         poke(bp - 4, asize | ALLOC_BIT);
         poke(footer_of(bp), asize | ALLOC_BIT);
         rest = next_blk(bp);
         poke(rest - 4, sz - asize);
         poke(footer_of(rest), sz - asize);
         poke(rest, 0);
         poke(rest + 4, 0);
         dummy = coalesce(rest);
      end else begin
         poke(bp - 4, sz | ALLOC_BIT);
         poke(footer_of(bp), sz | ALLOC_BIT);
      end
   endfunction

   function automatic void heap_init();
      efl_word_type dummy;
      foreach (heap_mem[i]) heap_mem[i] = 0;
      limit_reg = 65536;
      poke(4, 8 | ALLOC_BIT);
      poke(8, 8 | ALLOC_BIT);
      poke(12, ALLOC_BIT);
      brk_off   = 16;
      list_head = 0;
      dummy = grow_heap(CHUNK_SIZE);
   endfunction

   function automatic alloc_result_type serve_request(input logic kind,
                                                      input logic [15:0] size,
                                                      input logic [15:0] off);
      alloc_result_type r;
      efl_word_type     asize, bp, sz, dummy;
      r.offset = 0;
      r.status = ST_DONE;
      if (kind == REQ_FREE) begin
         if (off != 0) begin
            sz = blk_size(off);
            poke(off - 4, sz);
            poke(footer_of(off), sz);
            poke(off + 4, 0);
            poke(off, 0);
            dummy = coalesce(off);
         end
      end else if (size == 0) r.status = ST_ZERO_SIZE;
      else begin
         asize = (size <= 8) ? 16 : ((32'(size) + 15) / 8) * 8;
         bp = search_list(asize);
         if (bp == 0) bp = grow_heap((asize > CHUNK_SIZE) ? asize : CHUNK_SIZE);
         if (bp == 0) r.status = ST_NO_SPACE;
         else begin
            split_blk(bp, asize);
            r.offset = bp[15:0];
         end
      end
      return r;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      fail_count++;
   endtask

   always @(posedge clock) begin
      alloc_result_type want;
      if (reset) begin
         heap_init();
         answer_q.delete();
      end else begin
         // check the response beat first; it always belongs to an older request
         if (rsp_valid && rsp_ready) begin
            if (answer_q.size() == 0)
               report_mismatch("response beat with nothing outstanding");
            else begin
               want = answer_q.pop_front();
               if (rsp_payload_offset !== want.offset)
                  report_mismatch($sformatf("payload_offset got %0d want %0d",
                                            rsp_payload_offset, want.offset));
               if (rsp_status !== want.status)
                  report_mismatch($sformatf("status got %0d want %0d",
                                            rsp_status, want.status));
            end
         end
         if (req_valid && req_ready)
            answer_q.push_back(serve_request(req_type, req_alloc_size, req_block_offset));
         if (csr_wr_en) limit_reg = 32'(csr_wr_data);
      end
      pending_count <= answer_q.size();
   end

endmodule

`default_nettype wire

@@ tb/sv/explicit_free_list_allocator_test.sv @@
`default_nettype none

module explicit_free_list_allocator_test import efl_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 4000000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_type = REQ_ALLOC;
   logic [15:0] req_alloc_size = '0;
   logic [15:0] req_block_offset = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [15:0] rsp_payload_offset;
   logic [1:0]  rsp_status;
   logic        csr_wr_en = 1'b0;
   logic [16:0] csr_wr_data = '0;

   int fail_count;
   int pending_count;
   int cycle_count = 0;

   // knobs shared by the stimulus and the receiver
   bit no_gaps    = 1'b0;
   bit long_hold  = 1'b0;

   // blocks handed out and not yet freed, plus kinds of requests in flight
   logic [15:0] live_q[$];
   logic        kind_q[$];

   always #1 clock = ~clock;

   explicit_free_list_allocator u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_type           (req_type),
      .req_alloc_size     (req_alloc_size),
      .req_block_offset   (req_block_offset),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_payload_offset (rsp_payload_offset),
      .rsp_status         (rsp_status),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data)
   );

   explicit_free_list_allocator_checker u_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_type           (req_type),
      .req_alloc_size     (req_alloc_size),
      .req_block_offset   (req_block_offset),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_payload_offset (rsp_payload_offset),
      .rsp_status         (rsp_status),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .fail_count         (fail_count),
      .pending_count      (pending_count)
   );

   // Hard stop in case the block hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("explicit_free_list_allocator_test: FAIL");
         $finish;
      end
   end

   // Track which allocations succeeded so frees only hit live blocks.
   always @(posedge clock) begin
      logic k;
      if (!reset) begin
         if (rsp_valid && rsp_ready && kind_q.size() != 0) begin
            k = kind_q.pop_front();
            if (k == REQ_ALLOC && rsp_status == ST_DONE && rsp_payload_offset != 0)
               live_q.push_back(rsp_payload_offset);
         end
         if (req_valid && req_ready) kind_q.push_back(req_type);
      end
   end

   // Receiver: mostly ready, short random stalls, now and then a long one,
   // and one very long hold-off on request so the block backs up.
   int hold_cnt = 0;
   always @(posedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else if (hold_cnt > 0) begin
         rsp_ready <= 1'b0;
         hold_cnt  <= hold_cnt - 1;
      end else if (long_hold) begin
         rsp_ready <= 1'b0;
         hold_cnt  <= 400;
         long_hold <= 1'b0;
      end else if (no_gaps) rsp_ready <= 1'b1;
      else if ($urandom_range(99) < 3) begin
         rsp_ready <= 1'b0;
         hold_cnt  <= $urandom_range(10, 40);
      end else rsp_ready <= ($urandom_range(99) < 70);
   end

   function automatic int gap_len();
      int r;
      if (no_gaps) return 0;
      r = $urandom_range(99);
      if (r < 50) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Offer one beat and hold it until taken; a random gap may follow.
   task automatic send_beat(input logic kind, input logic [15:0] size, input logic [15:0] off);
      int gap;
      req_valid        <= 1'b1;
      req_type         <= kind;
      req_alloc_size   <= size;
      req_block_offset <= off;
      @(posedge clock);
      while (!(req_valid && req_ready)) @(posedge clock);
      gap = gap_len();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Ignored fields carry random noise so every bit toggles.
   task automatic alloc_beat(input logic [15:0] size);
      send_beat(REQ_ALLOC, size, 16'($urandom_range(0, 65535)));
   endtask

   task automatic free_beat(input logic [15:0] off);
      send_beat(REQ_FREE, 16'($urandom_range(0, 65535)), off);
   endtask

   task automatic free_live(input int idx);
      logic [15:0] off;
      off = live_q[idx];
      live_q.delete(idx);
      free_beat(off);
   endtask

   task automatic free_value(input logic [15:0] off);
      foreach (live_q[i])
         if (live_q[i] == off) begin
            free_live(i);
            return;
         end
   endtask

   // Drain everything, then let the sequencer settle before touching the CSR.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0 || kind_q.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   task automatic write_limit(input logic [16:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      @(posedge clock);
   endtask

   task automatic random_beats(input int count);
      int r;
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(99);
         if (live_q.size() == 0 || (r < 55 && live_q.size() < 60)) begin
            r = $urandom_range(99);
            if (r < 80) alloc_beat(16'($urandom_range(1, 256)));
            else if (r < 92) alloc_beat(16'($urandom_range(257, 6000)));
            else if (r < 97) alloc_beat(16'd0);
            else alloc_beat(16'($urandom_range(0, 65535)));
         end else if ($urandom_range(99) < 8) free_beat(16'd0);
         else free_live($urandom_range(0, live_q.size() - 1));
      end
   endtask

   initial begin
      logic [15:0] a, b, c;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: zero size, rounding edges, extension, oversize, null free.
      alloc_beat(16'd0);
      alloc_beat(16'd1);
      alloc_beat(16'd8);
      alloc_beat(16'd9);
      alloc_beat(16'd24);
      alloc_beat(16'd100);
      alloc_beat(16'd4000);
      alloc_beat(16'd5000);
      alloc_beat(16'hFFFF);
      alloc_beat(16'd8);
      alloc_beat(16'd40);
      alloc_beat(16'd40);
      alloc_beat(16'd40);
      free_beat(16'd0);
      drain();
      // free outer pair of three neighbors, then the middle: joins both sides
      if (live_q.size() >= 11) begin
         a = live_q[8];
         b = live_q[10];
         c = live_q[9];
         free_value(a);
         free_value(b);
         free_value(c);
         free_live(6);
         alloc_beat(16'd16);
         alloc_beat(16'd24);
      end
      drain();

      // Phase 1: smallest legal limit.
      write_limit(17'd4112);
      random_beats(120);
      drain();

      // Phase 2: top of the register range, with a long receiver hold-off.
      write_limit(17'h1FFFF);
      long_hold <= 1'b1;
      random_beats(140);
      drain();

      // Phase 3: a middling limit.
      write_limit(17'd20000);
      random_beats(120);
      drain();

      // Phase 4: full heap, first with no idling on either side, then with idling.
      write_limit(17'd65536);
      no_gaps = 1'b1;
      random_beats(120);
      no_gaps = 1'b0;
      random_beats(120);
      drain();

      if (fail_count == 0)
         $display("explicit_free_list_allocator_test: PASS");
      else
         $display("explicit_free_list_allocator_test: FAIL");
      $finish;
   end

endmodule

`default_nettype wire
